// ===== hdl/bmprgb_pkg.sv =====
// Shared types and constants for the BMP-to-RGB565 pixel decoder.
// Used by the top level and the testbench; no dependencies.

package bmprgb_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_PIXELS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  // Configuration register indexes
  localparam logic [7:0] CFG_ORIGIN_X = 8'd0;
  localparam logic [7:0] CFG_ORIGIN_Y = 8'd1;
  localparam logic [7:0] CFG_STEP_X   = 8'd2;
  localparam logic [7:0] CFG_STEP_Y   = 8'd3;

  // File byte positions
  localparam logic [31:0] IDX_MARK0     = 32'd0;
  localparam logic [31:0] IDX_MARK1     = 32'd1;
  localparam logic [31:0] IDX_OFS_LO    = 32'd10;
  localparam logic [31:0] IDX_OFS_HI    = 32'd13;
  localparam logic [31:0] IDX_HDR_SIZE  = 32'd14;
  localparam logic [31:0] IDX_WIDTH_LO  = 32'd18;
  localparam logic [31:0] IDX_WIDTH_HI  = 32'd21;
  localparam logic [31:0] IDX_HEIGHT_LO = 32'd22;
  localparam logic [31:0] IDX_HEIGHT_HI = 32'd25;
  localparam logic [31:0] IDX_BPP       = 32'd28;
  localparam logic [31:0] IDX_COMPRESS  = 32'd30;
  localparam logic [31:0] IDX_PAL_LO    = 32'd46;
  localparam logic [31:0] IDX_PAL_HI    = 32'd47;
  localparam logic [31:0] IDX_PAL_FIX   = 32'd49;
  localparam logic [31:0] IDX_VERDICT   = 32'd53;
  localparam logic [31:0] IDX_MASK_LO   = 32'd54;
  localparam logic [31:0] IDX_MASK_HI   = 32'd55;

  localparam logic [7:0]  MARK_B        = 8'h42;  // 'B'
  localparam logic [7:0]  MARK_M        = 8'h4D;  // 'M'
  localparam logic [15:0] RED_MASK_565  = 16'hF800;
  localparam logic [7:0]  MIN_HDR_SIZE  = 8'd40;
  localparam logic [7:0]  BPP_16        = 8'd16;
  localparam logic [31:0] MIN_OFFSET    = 32'd54;  // 14 file + 40 info header

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] color;
    logic        last_pixel;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  bits_per_pixel;
    logic [15:0] palette_entries;
    logic        is_565;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] byte_index;
    logic [31:0] pixel_offset;
    logic [7:0]  header_size;
    logic [31:0] width;
    logic [31:0] height;
    logic [7:0]  bpp;
    logic [7:0]  compress;
    logic [15:0] palette;
    logic        mask565;
    logic        marker_ok;
    logic [15:0] color_bytes;
    logic [1:0]  byte_in_pixel;
    logic [15:0] column_count;
    logic [15:0] row_count;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase: PH_HEADER, byte_index: 32'd0, pixel_offset: 32'd0, header_size: 8'd0,
    width: 32'd0, height: 32'd0, bpp: 8'd0, compress: 8'd0, palette: 16'd0,
    mask565: 1'b0, marker_ok: 1'b0, color_bytes: 16'd0, byte_in_pixel: 2'd0,
    column_count: 16'd0, row_count: 16'd0
  };

  // Replace one byte of a little-endian 32-bit field
  function automatic logic [31:0] put_byte(input logic [31:0] word,
                                           input logic [1:0]  pos,
                                           input logic [7:0]  b);
    logic [31:0] w;
    w = word;
    unique case (pos)
      2'd0: w[7:0]   = b;
      2'd1: w[15:8]  = b;
      2'd2: w[23:16] = b;
      2'd3: w[31:24] = b;
      default: w = word;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/bmprgb_chan_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
// Payload types come from bmprgb_pkg.

interface bmprgb_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/bmp_stream_to_rgb565_pixels_core.sv =====
// BMP byte-stream decoder top level: header parse, verdict, RGB565 pixel writes.
// Depends on bmprgb_pkg and bmprgb_chan_if.
//
// Usage
//   in_ch  : one file byte per item (data_byte, first_byte). first_byte marks
//            byte 0 of a file and restarts the parser before that byte is used.
//   out_ch : at most one item per input byte: a header verdict (accept or
//            reject, with the parsed width, height, bpp, palette count, 565
//            flag) on the header byte at offset-1 (never before byte 53), then
//            one pixel write per B,G,R triple, last_pixel on the final one.
//   cfg_ch : register writes (index, data), always ready; origin and step
//            registers are read live.
// Output and throughput
//   A result is registered and shows on out_ch in the cycle after its byte is
//   taken. One byte per clock is sustained: the single output register is
//   refilled in the same cycle that out_ch takes its item, so in_ch stalls
//   only while a result is held by out_ch.
// Reset
//   Synchronous, active low: parser back to header phase, registers zero,
//   out_ch empty.

module bmp_stream_to_rgb565_pixels_core #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  bmprgb_chan_if.sink   in_ch,
  bmprgb_chan_if.source out_ch,
  bmprgb_chan_if.sink   cfg_ch
);

  // ---------------------------------------------------------------- config
  logic [15:0] origin_x_r, origin_y_r;
  logic [1:0]  step_x_r, step_y_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      step_x_r   <= '0;
      step_y_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        bmprgb_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_ch.data.data;
        bmprgb_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_ch.data.data;
        bmprgb_pkg::CFG_STEP_X:   step_x_r   <= cfg_ch.data.data[1:0];
        bmprgb_pkg::CFG_STEP_Y:   step_y_r   <= cfg_ch.data.data[1:0];
        default: ;
      endcase
    end
  end

  // Step of -2..1, sign-extended to the cursor width
  logic [COORD_BITS-1:0] dx, dy, org_x, org_y;
  assign dx    = {{(COORD_BITS-2){step_x_r[1]}}, step_x_r};
  assign dy    = {{(COORD_BITS-2){step_y_r[1]}}, step_y_r};
  assign org_x = origin_x_r[COORD_BITS-1:0];
  assign org_y = origin_y_r[COORD_BITS-1:0];

  // ---------------------------------------------------------------- state
  bmprgb_pkg::parse_state_t st_r, st_nxt, cur;
  logic [COORD_BITS-1:0]    cursor_x_r, cursor_y_r, cursor_x_nxt, cursor_y_nxt;
  logic [COORD_BITS-1:0]    cx, cy;
  logic                     out_valid_r;
  bmprgb_pkg::out_item_t    out_item_r, res;
  logic                     res_valid;
  logic                     accept;

  // Output register frees up in the cycle its item is taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Header byte bookkeeping
  logic [31:0] idx;
  logic [1:0]  pos;
  logic [7:0]  b;
  logic        verdict, ok;
  logic [15:0] mask_word, pal_fix;
  logic [31:0] ofs_less;
  // Pixel bookkeeping
  logic        col_major, last, row_end;
  logic [15:0] w16, h16, col_inc;

  always_comb begin
    // first_byte clears the parse state before the byte is used
    cur = in_ch.data.first_byte ? bmprgb_pkg::PARSE_CLEAR : st_r;
    cx  = in_ch.data.first_byte ? '0 : cursor_x_r;
    cy  = in_ch.data.first_byte ? '0 : cursor_y_r;

    st_nxt       = cur;
    cursor_x_nxt = cx;
    cursor_y_nxt = cy;
    res          = '0;
    res_valid    = 1'b0;

    b         = in_ch.data.data_byte;
    idx       = cur.byte_index;
    pos       = 2'(idx[1:0] - 2'd2);  // fields start 2 bytes past a word boundary
    ofs_less  = cur.pixel_offset - bmprgb_pkg::MIN_OFFSET;
    pal_fix   = {2'b00, ofs_less[15:2]};
    mask_word = {b, cur.color_bytes[7:0]};
    verdict   = 1'b0;
    ok        = 1'b0;

    w16       = cur.width[15:0];
    h16       = cur.height[15:0];
    col_inc   = cur.column_count + 16'd1;
    col_major = (step_x_r == 2'd1) && (step_y_r == 2'd1);
    last      = (col_inc == w16) && ((cur.row_count + 16'd1) == h16);
    row_end   = col_inc >= w16;

    unique case (cur.phase)
      bmprgb_pkg::PH_HEADER: begin
        // field capture
        if (idx == bmprgb_pkg::IDX_MARK0) begin
          st_nxt.marker_ok = (b == bmprgb_pkg::MARK_B);
        end else if (idx == bmprgb_pkg::IDX_MARK1) begin
          st_nxt.marker_ok = cur.marker_ok && (b == bmprgb_pkg::MARK_M);
        end else if (idx >= bmprgb_pkg::IDX_OFS_LO && idx <= bmprgb_pkg::IDX_OFS_HI) begin
          st_nxt.pixel_offset = bmprgb_pkg::put_byte(cur.pixel_offset, pos, b);
        end else if (idx == bmprgb_pkg::IDX_HDR_SIZE) begin
          st_nxt.header_size = b;
        end else if (idx >= bmprgb_pkg::IDX_WIDTH_LO && idx <= bmprgb_pkg::IDX_WIDTH_HI) begin
          st_nxt.width = bmprgb_pkg::put_byte(cur.width, pos, b);
        end else if (idx >= bmprgb_pkg::IDX_HEIGHT_LO &&
                     idx <= bmprgb_pkg::IDX_HEIGHT_HI) begin
          st_nxt.height = bmprgb_pkg::put_byte(cur.height, pos, b);
        end else if (idx == bmprgb_pkg::IDX_BPP) begin
          st_nxt.bpp = b;
        end else if (idx == bmprgb_pkg::IDX_COMPRESS) begin
          st_nxt.compress = b;
        end else if (idx == bmprgb_pkg::IDX_PAL_LO) begin
          st_nxt.palette[7:0] = b;
        end else if (idx == bmprgb_pkg::IDX_PAL_HI) begin
          st_nxt.palette[15:8] = b;
        end else if (idx == bmprgb_pkg::IDX_PAL_FIX) begin
          // zero palette count: derive it from the space before the pixels
          if (cur.palette == 16'd0 && pal_fix != 16'd0) st_nxt.palette = pal_fix;
        end else if (idx == bmprgb_pkg::IDX_MASK_LO) begin
          st_nxt.color_bytes = {8'd0, b};
        end else if (idx == bmprgb_pkg::IDX_MASK_HI) begin
          if (cur.bpp == bmprgb_pkg::BPP_16 && cur.header_size > bmprgb_pkg::MIN_HDR_SIZE &&
              mask_word == bmprgb_pkg::RED_MASK_565)
            st_nxt.mask565 = 1'b1;
        end
        st_nxt.byte_index = idx + 32'd1;

        verdict = (idx >= bmprgb_pkg::IDX_VERDICT) &&
                  ({1'b0, idx} + 33'd1 >= {1'b0, cur.pixel_offset});
        ok = st_nxt.marker_ok && st_nxt.header_size >= bmprgb_pkg::MIN_HDR_SIZE &&
             st_nxt.compress == 8'd0 && st_nxt.pixel_offset >= bmprgb_pkg::MIN_OFFSET &&
             st_nxt.width[31:16] == 16'd0 && st_nxt.height[31:16] == 16'd0;

        if (verdict) begin
          res_valid           = 1'b1;
          res.kind            = ok ? bmprgb_pkg::KIND_ACCEPT : bmprgb_pkg::KIND_REJECT;
          res.image_width     = st_nxt.width[15:0];
          res.image_height    = st_nxt.height[15:0];
          res.bits_per_pixel  = st_nxt.bpp;
          res.palette_entries = st_nxt.palette;
          res.is_565          = st_nxt.mask565;
          st_nxt.phase        = bmprgb_pkg::PH_DONE;
          if (ok && st_nxt.width != 32'd0 && st_nxt.height != 32'd0) begin
            st_nxt.phase         = bmprgb_pkg::PH_PIXELS;
            cursor_x_nxt         = org_x;
            cursor_y_nxt         = org_y;
            st_nxt.column_count  = '0;
            st_nxt.row_count     = '0;
            st_nxt.color_bytes   = '0;
            st_nxt.byte_in_pixel = '0;
          end
        end
      end

      bmprgb_pkg::PH_PIXELS: begin
        if (cur.byte_in_pixel == 2'd1) begin
          st_nxt.color_bytes[15:8] = b;  // green
          st_nxt.byte_in_pixel     = 2'd2;
        end else if (cur.byte_in_pixel != 2'd2) begin
          st_nxt.color_bytes   = {8'd0, b};  // blue
          st_nxt.byte_in_pixel = 2'd1;
        end else begin
          // red byte completes the triple
          res_valid            = 1'b1;
          res.kind             = bmprgb_pkg::KIND_PIXEL;
          res.pixel_x          = 16'(cx);
          res.pixel_y          = 16'(cy);
          res.color            = {b[7:3], cur.color_bytes[15:10], cur.color_bytes[7:3]};
          res.last_pixel       = last;
          st_nxt.byte_in_pixel = 2'd0;

          if (col_major) cursor_y_nxt = cy + dy;
          else           cursor_x_nxt = cx + dx;

          st_nxt.column_count = col_inc;
          if (row_end) begin
            st_nxt.column_count = '0;
            st_nxt.row_count    = cur.row_count + 16'd1;
            if (col_major) begin
              cursor_x_nxt = cx + dx;
              cursor_y_nxt = org_y;
            end else begin
              cursor_y_nxt = cy + dy;
              cursor_x_nxt = org_x;
            end
          end
          if (last) st_nxt.phase = bmprgb_pkg::PH_DONE;
        end
      end

      bmprgb_pkg::PH_DONE: ;  // bytes ignored until the next first_byte

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= bmprgb_pkg::PARSE_CLEAR;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        st_r       <= st_nxt;
        cursor_x_r <= cursor_x_nxt;
        cursor_y_r <= cursor_y_nxt;
      end
      if (in_ch.ready) out_valid_r <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) out_item_r <= res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // ---------------------------------------------------------------- checks
  // A verdict moves the parser out of the header phase
  a_verdict_leaves_header: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_valid && res.kind != bmprgb_pkg::KIND_PIXEL)
      |=> st_r.phase != bmprgb_pkg::PH_HEADER)
    else $error("header phase kept after verdict");

  // The final pixel ends the image
  a_last_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_valid && res.last_pixel) |=> st_r.phase == bmprgb_pkg::PH_DONE)
    else $error("pixel phase kept after last pixel");

  // Pixel phase only with a non-empty image
  a_pixels_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == bmprgb_pkg::PH_PIXELS |-> (st_r.width != 32'd0 && st_r.height != 32'd0))
    else $error("pixel phase with empty image");

  // A result is never dropped: a held item stays while the sink stalls
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !accept)
    else $error("input taken while result is held");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the BMP byte-stream to RGB565 pixel decoder.
// Needs bmprgb_pkg, bmprgb_chan_if and bmp_stream_to_rgb565_pixels_core.
// A built-in decoder model predicts every verdict and every pixel write.
`timescale 1ns / 1ps

module testbench;

  // Step register patterns (2-bit two's complement)
  localparam logic [1:0] STEP_NONE  = 2'b00;
  localparam logic [1:0] STEP_FWD   = 2'b01;
  localparam logic [1:0] STEP_BACK2 = 2'b10;
  localparam logic [1:0] STEP_BACK  = 2'b11;

  localparam int SETTLE_CYCLES = 4;   // output is registered
  localparam int HOLD_CYCLES   = 60;  // long receiver hold-off

  // Header fields used to build one file
  typedef struct packed {
    logic [7:0]  mark0;
    logic [7:0]  mark1;
    logic [31:0] ofs;
    logic [7:0]  hsz;
    logic [31:0] w;
    logic [31:0] h;
    logic [7:0]  bpp;
    logic [7:0]  comp;
    logic [15:0] pal;
    logic [15:0] mask;
  } bmp_hdr_t;

  logic clk = 1'b0;
  logic rst_n;

  bmprgb_chan_if #(.payload_t(bmprgb_pkg::in_item_t))  in_ch ();
  bmprgb_chan_if #(.payload_t(bmprgb_pkg::out_item_t)) out_ch ();
  bmprgb_chan_if #(.payload_t(bmprgb_pkg::cfg_item_t)) cfg_ch ();

  bmp_stream_to_rgb565_pixels_core #(.COORD_BITS(16)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Idling controls, changed by the test sequence
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;        // receiver hold-off, counted down by the ready process
  int bad_fields;

  bmprgb_pkg::out_item_t decoded_q[$];

  // ---------------------------------------------------------------------
  // Decoder model state: registers plus parse state
  // ---------------------------------------------------------------------
  logic [15:0] reg_org_x, reg_org_y;
  logic [1:0]  reg_stp_x, reg_stp_y;

  bmprgb_pkg::phase_t ps_phase;
  logic [31:0] ps_idx, ps_ofs, ps_w, ps_h;
  logic [7:0]  ps_hsz, ps_bpp, ps_comp;
  logic [15:0] ps_pal, ps_colb, ps_col, ps_row, ps_cx, ps_cy;
  logic        ps_m565, ps_mark;
  logic [1:0]  ps_bip;

  function automatic void clear_decoder();
    ps_phase = bmprgb_pkg::PH_HEADER;
    ps_idx = '0; ps_ofs = '0; ps_w = '0; ps_h = '0;
    ps_hsz = '0; ps_bpp = '0; ps_comp = '0;
    ps_pal = '0; ps_colb = '0; ps_col = '0; ps_row = '0; ps_cx = '0; ps_cy = '0;
    ps_m565 = 1'b0; ps_mark = 1'b0; ps_bip = '0;
  endfunction

  function automatic logic [15:0] step_coord(logic [15:0] c, logic [1:0] s);
    return c + {{14{s[1]}}, s};
  endfunction

  // Advance the model by one file byte; returns 1 when the byte makes a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                     output bmprgb_pkg::out_item_t r);
    logic [31:0] i, w, h;
    logic [1:0]  pos;
    logic [15:0] t;
    logic [7:0]  grn, blu;
    logic        ok, colmaj, last;
    r = '0;
    if (first) clear_decoder();

    if (ps_phase == bmprgb_pkg::PH_HEADER) begin
      i = ps_idx;
      pos = 2'(i - 32'd2);  // byte lane inside a 32-bit little-endian field
      if (i == bmprgb_pkg::IDX_MARK0) ps_mark = (b == bmprgb_pkg::MARK_B);
      else if (i == bmprgb_pkg::IDX_MARK1) ps_mark = ps_mark && (b == bmprgb_pkg::MARK_M);
      else if (i >= bmprgb_pkg::IDX_OFS_LO && i <= bmprgb_pkg::IDX_OFS_HI)
        ps_ofs[8*pos +: 8] = b;
      else if (i == bmprgb_pkg::IDX_HDR_SIZE) ps_hsz = b;
      else if (i >= bmprgb_pkg::IDX_WIDTH_LO && i <= bmprgb_pkg::IDX_WIDTH_HI)
        ps_w[8*pos +: 8] = b;
      else if (i >= bmprgb_pkg::IDX_HEIGHT_LO && i <= bmprgb_pkg::IDX_HEIGHT_HI)
        ps_h[8*pos +: 8] = b;
      else if (i == bmprgb_pkg::IDX_BPP) ps_bpp = b;
      else if (i == bmprgb_pkg::IDX_COMPRESS) ps_comp = b;
      else if (i == bmprgb_pkg::IDX_PAL_LO) ps_pal[7:0] = b;
      else if (i == bmprgb_pkg::IDX_PAL_HI) ps_pal[15:8] = b;
      else if (i == bmprgb_pkg::IDX_PAL_FIX) begin
        // zero palette count: derive it from the gap before the pixels
        if (ps_pal == '0) begin
          t = 16'(ps_ofs - bmprgb_pkg::MIN_OFFSET) >> 2;
          if (t != '0) ps_pal = t;
        end
      end
      else if (i == bmprgb_pkg::IDX_MASK_LO) ps_colb = {8'h00, b};
      else if (i == bmprgb_pkg::IDX_MASK_HI) begin
        if (ps_bpp == bmprgb_pkg::BPP_16 && ps_hsz > bmprgb_pkg::MIN_HDR_SIZE &&
            {b, ps_colb[7:0]} == bmprgb_pkg::RED_MASK_565)
          ps_m565 = 1'b1;
      end
      ps_idx = i + 32'd1;
      // verdict on byte offset-1, never before the end of the 54-byte header
      if (i >= bmprgb_pkg::IDX_VERDICT && {1'b0, i} + 33'd1 >= {1'b0, ps_ofs}) begin
        ok = ps_mark && ps_hsz >= bmprgb_pkg::MIN_HDR_SIZE && ps_comp == '0 &&
             ps_ofs >= bmprgb_pkg::MIN_OFFSET && ps_w <= 32'h0000_FFFF &&
             ps_h <= 32'h0000_FFFF;
        r.kind = ok ? bmprgb_pkg::KIND_ACCEPT : bmprgb_pkg::KIND_REJECT;
        r.image_width = ps_w[15:0];
        r.image_height = ps_h[15:0];
        r.bits_per_pixel = ps_bpp;
        r.palette_entries = ps_pal;
        r.is_565 = ps_m565;
        ps_phase = bmprgb_pkg::PH_DONE;
        if (ok && ps_w != '0 && ps_h != '0) begin
          ps_phase = bmprgb_pkg::PH_PIXELS;
          ps_cx = reg_org_x; ps_cy = reg_org_y;
          ps_col = '0; ps_row = '0; ps_colb = '0; ps_bip = '0;
        end
        return 1'b1;
      end
      return 1'b0;
    end

    if (ps_phase != bmprgb_pkg::PH_PIXELS) return 1'b0;

    // B, G collected first; R completes the pixel
    if (ps_bip == 2'd1) begin
      ps_colb[15:8] = b;
      ps_bip = 2'd2;
      return 1'b0;
    end
    if (ps_bip != 2'd2) begin
      ps_colb = {8'h00, b};
      ps_bip = 2'd1;
      return 1'b0;
    end

    blu = ps_colb[7:0];
    grn = ps_colb[15:8];
    w = {16'h0, ps_w[15:0]};
    h = {16'h0, ps_h[15:0]};
    colmaj = (reg_stp_x == STEP_FWD && reg_stp_y == STEP_FWD);
    last = ({16'h0, ps_col} + 32'd1 == w) && ({16'h0, ps_row} + 32'd1 == h);

    r.kind = bmprgb_pkg::KIND_PIXEL;
    r.pixel_x = ps_cx;
    r.pixel_y = ps_cy;
    r.color = {b[7:3], grn[7:2], blu[7:3]};
    r.last_pixel = last;
    ps_bip = 2'd0;

    if (colmaj) ps_cy = step_coord(ps_cy, reg_stp_y);
    else ps_cx = step_coord(ps_cx, reg_stp_x);

    ps_col = ps_col + 16'd1;
    if ({16'h0, ps_col} >= w) begin
      ps_col = '0;
      ps_row = ps_row + 16'd1;
      if (colmaj) begin
        ps_cx = step_coord(ps_cx, reg_stp_x);
        ps_cy = reg_org_y;
      end else begin
        ps_cy = step_coord(ps_cy, reg_stp_y);
        ps_cx = reg_org_x;
      end
    end
    if (last) ps_phase = bmprgb_pkg::PH_DONE;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random ready, or a long counted hold-off when requested
  // ---------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted item against the oldest prediction
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      bad_fields++;
      if (bad_fields <= 10)
        $display("%0t ns: %s expected %0h got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bmprgb_pkg::out_item_t got, want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (decoded_q.size() == 0) begin
        bad_fields++;
        if (bad_fields <= 10)
          $display("%0t ns: unexpected item, kind %0d", $realtime, got.kind);
      end else begin
        want = decoded_q.pop_front();
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("pixel_x", 32'(got.pixel_x), 32'(want.pixel_x));
        check_field("pixel_y", 32'(got.pixel_y), 32'(want.pixel_y));
        check_field("color", 32'(got.color), 32'(want.color));
        check_field("last_pixel", 32'(got.last_pixel), 32'(want.last_pixel));
        check_field("image_width", 32'(got.image_width), 32'(want.image_width));
        check_field("image_height", 32'(got.image_height), 32'(want.image_height));
        check_field("bits_per_pixel", 32'(got.bits_per_pixel), 32'(want.bits_per_pixel));
        check_field("palette_entries", 32'(got.palette_entries),
                    32'(want.palette_entries));
        check_field("is_565", 32'(got.is_565), 32'(want.is_565));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Offer one file byte; valid stays up afterwards so back-to-back bytes
  // can follow without a gap. The model advances on the accepting edge.
  task automatic push_file_byte(logic [7:0] b, logic first);
    bmprgb_pkg::out_item_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{data_byte: b, first_byte: first};
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (decode_byte(b, first, r)) decoded_q.push_back(r);
  endtask

  // Stop offering and let every predicted item come out
  task automatic wait_results_drained();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the decoder is idle
  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, data: val};
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      bmprgb_pkg::CFG_ORIGIN_X: reg_org_x = val;
      bmprgb_pkg::CFG_ORIGIN_Y: reg_org_y = val;
      bmprgb_pkg::CFG_STEP_X:   reg_stp_x = val[1:0];
      bmprgb_pkg::CFG_STEP_Y:   reg_stp_y = val[1:0];
      default: ;
    endcase
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] ox, logic [15:0] oy, logic [1:0] sx, logic [1:0] sy);
    wait_results_drained();
    write_reg(bmprgb_pkg::CFG_ORIGIN_X, ox);
    write_reg(bmprgb_pkg::CFG_ORIGIN_Y, oy);
    // upper data bits are don't-care for the step registers
    write_reg(bmprgb_pkg::CFG_STEP_X, {14'($urandom), sx});
    write_reg(bmprgb_pkg::CFG_STEP_Y, {14'($urandom), sy});
  endtask

  function automatic bmp_hdr_t good_header(logic [31:0] w, logic [31:0] h);
    bmp_hdr_t f;
    f.mark0 = bmprgb_pkg::MARK_B; f.mark1 = bmprgb_pkg::MARK_M;
    f.ofs = bmprgb_pkg::MIN_OFFSET; f.hsz = bmprgb_pkg::MIN_HDR_SIZE;
    f.w = w; f.h = h;
    f.bpp = 8'd24; f.comp = '0; f.pal = '0; f.mask = '0;
    return f;
  endfunction

  // Byte i of the file header; unparsed positions carry random filler
  function automatic logic [7:0] hdr_byte(bmp_hdr_t f, logic [31:0] i);
    logic [1:0] pos;
    pos = 2'(i - 32'd2);
    if (i == bmprgb_pkg::IDX_MARK0) return f.mark0;
    if (i == bmprgb_pkg::IDX_MARK1) return f.mark1;
    if (i >= bmprgb_pkg::IDX_OFS_LO && i <= bmprgb_pkg::IDX_OFS_HI) return f.ofs[8*pos +: 8];
    if (i == bmprgb_pkg::IDX_HDR_SIZE) return f.hsz;
    if (i >= bmprgb_pkg::IDX_WIDTH_LO && i <= bmprgb_pkg::IDX_WIDTH_HI) return f.w[8*pos +: 8];
    if (i >= bmprgb_pkg::IDX_HEIGHT_LO && i <= bmprgb_pkg::IDX_HEIGHT_HI)
      return f.h[8*pos +: 8];
    if (i == bmprgb_pkg::IDX_BPP) return f.bpp;
    if (i == bmprgb_pkg::IDX_COMPRESS) return f.comp;
    if (i == bmprgb_pkg::IDX_PAL_LO) return f.pal[7:0];
    if (i == bmprgb_pkg::IDX_PAL_HI) return f.pal[15:8];
    if (i == bmprgb_pkg::IDX_MASK_LO) return f.mask[7:0];
    if (i == bmprgb_pkg::IDX_MASK_HI) return f.mask[15:8];
    return 8'($urandom);
  endfunction

  // Header up to the pixel offset (a short one is padded out past the
  // verdict byte, a huge one is cut off), then body_bytes random bytes.
  task automatic send_file(bmp_hdr_t f, int unsigned body_bytes);
    logic [31:0] hdr_len;
    if (f.ofs < bmprgb_pkg::MIN_OFFSET) hdr_len = bmprgb_pkg::MIN_OFFSET + 32'd2;
    else if (f.ofs > 32'd200) hdr_len = 32'd120;
    else hdr_len = f.ofs;
    for (logic [31:0] i = 0; i < hdr_len; i++)
      push_file_byte(hdr_byte(f, i), i == 0);
    repeat (body_bytes) push_file_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_pixel(logic [7:0] blu, logic [7:0] grn, logic [7:0] red);
    push_file_byte(blu, 1'b0);
    push_file_byte(grn, 1'b0);
    push_file_byte(red, 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Bottom-up row order with color extremes; trailing bytes are ignored
  task automatic test_row_major();
    set_config(16'd10, 16'd20, STEP_FWD, STEP_BACK);
    send_file(good_header(3, 2), 0);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    push_file_byte(8'hA5, 1'b0);
    push_file_byte(8'h5A, 1'b0);
  endtask

  // Both steps +1 draws column by column; origin at the top wraps
  task automatic test_column_major();
    set_config(16'hFFFF, 16'hFFFE, STEP_FWD, STEP_FWD);
    send_file(good_header(2, 3), 18);
  endtask

  // Negative steps and the -2 pattern; 565 mask ending on the verdict byte
  task automatic test_reverse_steps();
    bmp_hdr_t f;
    set_config(16'd0, 16'd0, STEP_BACK, STEP_BACK2);
    f = good_header(2, 2); f.bpp = bmprgb_pkg::BPP_16; f.hsz = 8'd56;
    f.ofs = 32'd56; f.mask = bmprgb_pkg::RED_MASK_565;
    send_file(f, 12);
  endtask

  task automatic test_empty_image();
    send_file(good_header(0, 3), 0);
    send_file(good_header(4, 0), 0);
  endtask

  // One file per reject cause; the same files cover the palette fix
  // (kept, derived, rounded to zero, wrapped) and the 565 flag cases
  task automatic test_rejects();
    bmp_hdr_t f;
    set_config(16'd0, 16'd0, STEP_FWD, STEP_NONE);
    f = good_header(2, 2); f.mark0 = 8'h41; f.ofs = 32'd70; f.pal = 16'h0001;
    send_file(f, 0);
    f = good_header(2, 2); f.mark1 = 8'h4E; f.bpp = bmprgb_pkg::BPP_16; f.hsz = 8'd56;
    f.ofs = 32'd56; f.mask = bmprgb_pkg::RED_MASK_565 | 16'h0001;
    send_file(f, 0);
    f = good_header(2, 2); f.hsz = bmprgb_pkg::MIN_HDR_SIZE - 8'd1; f.ofs = 32'd57;
    send_file(f, 0);
    f = good_header(2, 2); f.comp = 8'd1; f.ofs = 32'd66; f.hsz = 8'hFF;
    f.mask = bmprgb_pkg::RED_MASK_565;
    send_file(f, 0);
    f = good_header(2, 2); f.ofs = 32'd50;               // fix wraps, then rejected
    send_file(f, 0);
    f = good_header(32'h0001_0000, 2); f.bpp = bmprgb_pkg::BPP_16; f.hsz = 8'd56;
    f.mask = bmprgb_pkg::RED_MASK_565; f.ofs = 32'd55;  // mask too late
    send_file(f, 0);
    f = good_header(2, 32'hFFFF_FFFF); f.bpp = bmprgb_pkg::BPP_16;
    f.mask = bmprgb_pkg::RED_MASK_565; f.ofs = 32'd56;  // header too short for flag
    send_file(f, 0);
  endtask

  // Restart with first_byte inside an image and inside a header
  task automatic test_restart();
    bmp_hdr_t f;
    set_config(16'hFFFE, 16'd0, STEP_NONE, STEP_BACK);
    send_file(good_header(16'hFFFF, 16'hFFFF), 7);       // largest accepted size
    f = good_header(2, 1);
    for (logic [31:0] i = 0; i < 20; i++) push_file_byte(hdr_byte(f, i), i == 0);
    send_file(good_header(2, 1), 6);
  endtask

  // Long receiver hold-off during the pixels so the block fills and stalls
  // its input, then a sender pause until every result is out
  task automatic test_backpressure();
    set_config(16'd100, 16'd200, STEP_BACK, STEP_NONE);
    send_file(good_header(3, 3), 0);
    rx_hold = HOLD_CYCLES;
    repeat (27) push_file_byte(8'($urandom), 1'b0);
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    tx_idle_pct = 32;
    rx_idle_pct = 65;
    rx_hold = 0;
    bad_fields = 0;
    reg_org_x = '0; reg_org_y = '0; reg_stp_x = '0; reg_stp_y = '0;
    clear_decoder();
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // sender idle chance 32 percent, receiver 65 percent
    test_row_major();
    test_column_major();
    test_reverse_steps();
    test_empty_image();

    // the other way round
    tx_idle_pct = 65;
    rx_idle_pct = 32;
    test_rejects();

    // no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_restart();
    test_backpressure();

    wait_results_drained();
    if (bad_fields == 0 && decoded_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bmprgb_pkg.sv
hdl/bmprgb_chan_if.sv
hdl/bmp_stream_to_rgb565_pixels_core.sv
tb/testbench.sv
